FILE: rtl/core/gamepad_report_byte_decoder_core_defines.svh
// Assertion macros for the gamepad report byte decoder core.
// Depends on nothing; files that check themselves include it by bare name.
`ifndef GAMEPAD_REPORT_BYTE_DECODER_CORE_DEFINES_SVH
`define GAMEPAD_REPORT_BYTE_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define GPRBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define GPRBD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GPRBD_ASSERT(label, prop, msg)
`define GPRBD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: rtl/core/gprbd_pkg.sv
// Shared codes and the hat lookup for the gamepad report byte decoder.
// No dependencies.
package gprbd_pkg;

    localparam logic [1:0] PH_INIT  = 2'd0;
    localparam logic [1:0] PH_HDR   = 2'd1;
    localparam logic [1:0] PH_BTN0  = 2'd2;
    localparam logic [1:0] PH_FINAL = 2'd3;

    localparam logic [1:0] ST_PENDING  = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    localparam logic [7:0] BYTE_HEADER = 8'h80;
    localparam logic [7:0] BYTE_HOME   = 8'h40;
    localparam logic [7:0] BYTE_RELALL = 8'h80;
    localparam logic [7:0] BYTE_FILLER = 8'hFF;

    localparam logic [3:0] HAT_NEUTRAL = 4'd0;
    localparam logic [3:0] HAT_MAX     = 4'd8;

    // Direction bits are {up, right, down, left}. Only single directions and
    // adjacent pairs map to a hat code; anything else is neutral.
    function automatic logic [3:0] hat_of_dirs(input logic [3:0] dirs);
        logic [3:0] hat;
        case (dirs)
            4'b1000: hat = 4'd1;
            4'b1100: hat = 4'd2;
            4'b0100: hat = 4'd3;
            4'b0110: hat = 4'd4;
            4'b0010: hat = 4'd5;
            4'b0011: hat = 4'd6;
            4'b0001: hat = 4'd7;
            4'b1001: hat = 4'd8;
            default: hat = HAT_NEUTRAL;
        endcase
        return hat;
    endfunction

endpackage

FILE: rtl/core/gamepad_report_byte_decoder_core.sv
// Gamepad report byte decoder: frames a byte stream into reports and holds buttons.
// The result beat of an accepted input beat is registered and offered in the cycle after it.
// Throughput: one beat per cycle unless the output stalls; framing step and decode
// fit between input port and the single result register, held state as feedback.
// Reset (rst_n low, asynchronous) returns the parser to its initial phase,
// releases every button, centers the hat and empties the result register.
`include "gamepad_report_byte_decoder_core_defines.svh"

module gamepad_report_byte_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream: one received byte per beat.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] action (1 = restart framing)
    // Result stream: one result per input beat.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] buttons, [8] home_pressed, [12:9] hat
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import gprbd_pkg::*;

    // Parser phase and held decoded state. The held state is also the result
    // payload, since a result always shows the state after its step.
    logic [1:0] phase_reg, phase_next;
    logic [7:0] first_byte_reg, first_byte_next;
    logic [7:0] held_buttons_reg, held_buttons_next;
    logic       held_home_reg, held_home_next;
    logic [3:0] held_hat_reg, held_hat_next;

    // Result register: valid flag and status code.
    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg, status_next;

    logic       in_fire;
    logic       action;
    logic [7:0] data_byte;

    // Report decode terms for the second button byte arriving now.
    logic [5:0] lo_bits;
    logic [1:0] hi_bits;
    logic [3:0] dirs;

    // The result register frees up in the same cycle its beat is taken, so a
    // new beat can enter every cycle while the downstream side keeps pace.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign action        = s_axis_tuser[0];
    assign data_byte     = s_axis_tdata;

    // A button byte equal to the release-all code clears its whole group.
    always_comb
    begin
        lo_bits = 6'd0;
        hi_bits = 2'd0;
        dirs    = 4'd0;
        if (first_byte_reg != BYTE_RELALL)
        begin
            lo_bits = first_byte_reg[5:0];
        end
        if (data_byte != BYTE_RELALL)
        begin
            hi_bits = data_byte[1:0];
            // {up, right, down, left} from byte bits 4, 3, 5, 2.
            dirs    = {data_byte[4], data_byte[3], data_byte[5], data_byte[2]};
        end
    end

    // Framing step for one beat.
    always_comb
    begin
        phase_next        = phase_reg;
        first_byte_next   = first_byte_reg;
        held_buttons_next = held_buttons_reg;
        held_home_next    = held_home_reg;
        held_hat_next     = held_hat_reg;
        status_next       = status_reg;
        out_valid_next    = out_valid_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_REJECTED;
            if (action)
            begin
                // Restart keeps the held state and only rewinds the parser.
                phase_next  = PH_INIT;
                status_next = ST_PENDING;
            end
            else
            begin
                case (phase_reg)
                    PH_INIT:
                    begin
                        if (data_byte == BYTE_HOME)
                        begin
                            // A lone home byte is a whole report.
                            held_home_next = 1'b1;
                            phase_next     = PH_FINAL;
                            status_next    = ST_ACCEPTED;
                        end
                        else if (data_byte == BYTE_HEADER)
                        begin
                            phase_next  = PH_HDR;
                            status_next = ST_PENDING;
                        end
                        else
                        begin
                            phase_next  = PH_FINAL;
                            status_next = ST_REJECTED;
                        end
                    end
                    PH_HDR:
                    begin
                        if (data_byte != BYTE_FILLER)
                        begin
                            first_byte_next = data_byte;
                            phase_next      = PH_BTN0;
                        end
                        status_next = ST_PENDING;
                    end
                    PH_BTN0:
                    begin
                        if (data_byte != BYTE_FILLER)
                        begin
                            held_buttons_next = {hi_bits, lo_bits};
                            held_home_next    = 1'b0;
                            held_hat_next     = hat_of_dirs(dirs);
                            phase_next        = PH_FINAL;
                            status_next       = ST_ACCEPTED;
                        end
                        else
                        begin
                            status_next = ST_PENDING;
                        end
                    end
                    default:
                    begin
                        // Once a report is done or a byte was refused, every
                        // data byte is refused until a restart.
                        phase_next  = PH_FINAL;
                        status_next = ST_REJECTED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_INIT;
            held_buttons_reg <= 8'd0;
            held_home_reg    <= 1'b0;
            held_hat_reg     <= HAT_NEUTRAL;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            held_buttons_reg <= held_buttons_next;
            held_home_reg    <= held_home_next;
            held_hat_reg     <= held_hat_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // The stored first button byte and the status code are payload only.
    always_ff @(posedge clk)
    begin
        first_byte_reg <= first_byte_next;
        status_reg     <= status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {3'd0, held_hat_reg, held_home_reg, held_buttons_reg};

    // A beat that ends or refuses a report leaves the parser in its final phase.
    `GPRBD_ASSERT(a_done_goes_final, (in_fire && !action && status_next != ST_PENDING) |=> (phase_reg == PH_FINAL), "report end or reject did not reach the final phase")
    // In the final phase every data byte is refused.
    `GPRBD_ASSERT(a_final_rejects, (in_fire && !action && phase_reg == PH_FINAL) |=> (m_axis_tvalid && m_axis_tuser == ST_REJECTED), "data byte in final phase was not rejected")
    // The held state only moves on an accepted report.
    `GPRBD_ASSERT(a_held_moves_on_accept, (!$stable(m_axis_tdata)) |-> (m_axis_tvalid && m_axis_tuser == ST_ACCEPTED), "held state changed without an accepted report")
    // The hat never leaves its code range.
    `GPRBD_ASSERT(a_hat_range, held_hat_reg <= HAT_MAX, "hat code out of range")

endmodule
